/* hdl/mmi_pkg.sv */
// Shared types and command/mode codes for the machine mode interlock controller.
package mmi_pkg;

  localparam int ActionBits = 4;
  localparam int ModeBits   = 3;
  localparam int CodeBits   = 8;

  typedef enum logic [ModeBits-1:0] {
    MODE_OFFLINE  = 3'd0,
    MODE_INIT     = 3'd1,
    MODE_IDLE     = 3'd2,
    MODE_RUNNING  = 3'd3,
    MODE_PAUSED   = 3'd4,
    MODE_STOPPING = 3'd5,
    MODE_FAULTED  = 3'd6,
    MODE_ESTOP    = 3'd7
  } mode_t;

  typedef enum logic [ActionBits-1:0] {
    ACT_INIT        = 4'd0,
    ACT_START       = 4'd1,
    ACT_PAUSE       = 4'd2,
    ACT_RESUME      = 4'd3,
    ACT_STOP        = 4'd4,
    ACT_RESET       = 4'd5,
    ACT_ESTOP       = 4'd6,
    ACT_CLEAR_ESTOP = 4'd7,
    ACT_FAULT       = 4'd8
  } action_t;

  // Decision for one request: new status plus fault code handling.
  typedef struct packed {
    logic  accepted;
    mode_t mode;
    logic  estop;
    logic  fault;
    logic  code_load;
    logic  code_clear;
  } mmi_ctl_t;

endpackage

/* hdl/mmi_decide.sv */
// Transition table check and next status for one request.
module mmi_decide
  import mmi_pkg::*;
(
  input  logic [ActionBits-1:0] action,
  input  mode_t                 mode,
  input  logic                  estop,
  input  logic                  fault,
  output mmi_ctl_t              ctl
);

  always_comb begin
    ctl            = '0;
    ctl.mode       = mode;
    ctl.estop      = estop;
    ctl.fault      = fault;
    case (action_t'(action))
      ACT_INIT: begin
        // pass through init to idle in one step
        if (mode == MODE_OFFLINE) begin
          ctl.accepted = 1'b1;
          ctl.mode     = MODE_IDLE;
        end
      end
      ACT_START, ACT_RESUME: begin
        if (!estop && !fault && (mode == MODE_IDLE || mode == MODE_PAUSED)) begin
          ctl.accepted = 1'b1;
          ctl.mode     = MODE_RUNNING;
        end
      end
      ACT_PAUSE: begin
        if (mode == MODE_RUNNING) begin
          ctl.accepted = 1'b1;
          ctl.mode     = MODE_PAUSED;
        end
      end
      ACT_STOP: begin
        // pass through stopping to idle in one step
        if (mode == MODE_RUNNING || mode == MODE_PAUSED) begin
          ctl.accepted = 1'b1;
          ctl.mode     = MODE_IDLE;
        end
      end
      ACT_RESET: begin
        if (mode == MODE_FAULTED) begin
          ctl.accepted   = 1'b1;
          ctl.mode       = MODE_IDLE;
          ctl.fault      = 1'b0;
          ctl.code_clear = 1'b1;
        end else if (mode == MODE_ESTOP && !estop) begin
          ctl.accepted = 1'b1;
          ctl.mode     = MODE_IDLE;
        end
      end
      ACT_ESTOP: begin
        if (mode != MODE_ESTOP) begin
          ctl.accepted = 1'b1;
          ctl.mode     = MODE_ESTOP;
          ctl.estop    = 1'b1;
        end
      end
      ACT_CLEAR_ESTOP: begin
        if (estop) begin
          ctl.accepted = 1'b1;
          ctl.estop    = 1'b0;
        end
      end
      ACT_FAULT: begin
        if (mode == MODE_INIT || mode == MODE_IDLE || mode == MODE_RUNNING ||
            mode == MODE_PAUSED || mode == MODE_STOPPING) begin
          ctl.accepted  = 1'b1;
          ctl.mode      = MODE_FAULTED;
          ctl.fault     = 1'b1;
          ctl.code_load = 1'b1;
        end
      end
      default: begin
        // unknown command: refuse, change nothing
      end
    endcase
  end

endmodule

/* hdl/machine_mode_interlock_fsm_unit.sv */
// Top level of the machine mode interlock controller.
//
// Usage:
//   Input channel (in_valid / in_stall / in_action / in_fault_code) carries
//   one command request per accepted cycle. Result channel (out_valid /
//   out_stall / out_*) returns exactly one result per request, in order:
//   accepted flag, mode, emergency-stop flag, fault flag and fault code.
//   A request passes through the input register, then the result register.
//   Throughput: one request per cycle while the receiver does not stall;
//   the status update is a single table decision between the input
//   register and the result register.
//   When the receiver stalls, the result register holds its request; the
//   input register still takes one more request, then in_stall rises until
//   the result is taken. in_stall never rises while the input register is
//   empty.
//   Reset (rst_n low, synchronous): mode goes offline, emergency-stop and
//   fault flags and the fault code clear, both registers empty.
//   The latched fault code keeps the low FAULT_CODE_BITS bits of
//   in_fault_code (at most eight).
module machine_mode_interlock_fsm_unit
  import mmi_pkg::*;
#(
  parameter int FAULT_CODE_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ActionBits-1:0] in_action,
  input  logic [CodeBits-1:0]   in_fault_code,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_accepted,
  output logic [ModeBits-1:0]   out_mode,
  output logic                  out_estop_latched,
  output logic                  out_fault_present,
  output logic [CodeBits-1:0]   out_latched_code
);

  // Stored code width: only the low bits of the eight-bit field survive.
  localparam int CodeW = (FAULT_CODE_BITS < CodeBits) ? FAULT_CODE_BITS : CodeBits;

  // Input register
  logic                  in_valid_r;
  logic [ActionBits-1:0] action_r;
  logic [CodeBits-1:0]   fault_code_r;

  // Controller status
  mode_t                 mode_r, mode_nxt;
  logic                  estop_r, estop_nxt;
  logic                  fault_r, fault_nxt;
  logic [CodeW-1:0]      code_r, code_nxt;

  // Result register
  logic                  out_valid_r;
  logic                  accepted_r;
  mode_t                 res_mode_r;
  logic                  res_estop_r;
  logic                  res_fault_r;
  logic [CodeBits-1:0]   res_code_r;

  mmi_ctl_t              ctl;
  logic                  advance;
  logic                  take_in;

  // Advance the held request when the result register is free or draining.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign take_in  = in_valid && !in_stall;

  mmi_decide u_decide (
    .action (action_r),
    .mode   (mode_r),
    .estop  (estop_r),
    .fault  (fault_r),
    .ctl    (ctl)
  );

  always_comb begin
    mode_nxt  = ctl.mode;
    estop_nxt = ctl.estop;
    fault_nxt = ctl.fault;
    code_nxt  = code_r;
    if (ctl.code_load) begin
      code_nxt = fault_code_r[CodeW-1:0];
    end else if (ctl.code_clear) begin
      code_nxt = '0;
    end
  end

  // Input register: load on accept, drop once handed on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (take_in) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      action_r     <= in_action;
      fault_code_r <= in_fault_code;
    end
  end

  // Status registers: commit the decision when the request advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_OFFLINE;
      estop_r <= 1'b0;
      fault_r <= 1'b0;
      code_r  <= '0;
    end else if (advance) begin
      mode_r  <= mode_nxt;
      estop_r <= estop_nxt;
      fault_r <= fault_nxt;
      code_r  <= code_nxt;
    end
  end

  // Result register: hold while stalled, clear when taken and nothing new.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      accepted_r  <= ctl.accepted;
      res_mode_r  <= mode_nxt;
      res_estop_r <= estop_nxt;
      res_fault_r <= fault_nxt;
      // report the code only while a fault is latched
      res_code_r  <= fault_nxt ? CodeBits'(code_nxt) : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = accepted_r;
  assign out_mode          = res_mode_r;
  assign out_estop_latched = res_estop_r;
  assign out_fault_present = res_fault_r;
  assign out_latched_code  = res_code_r;

endmodule

/* hdl/mmi_checker.sv */
// Port-level checks for the machine mode interlock controller, with its bind.
module mmi_checker
  import mmi_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_accepted,
  input logic [ModeBits-1:0]   out_mode,
  input logic                  out_estop_latched,
  input logic                  out_fault_present,
  input logic [CodeBits-1:0]   out_latched_code
);

  // A stalled result stays and holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_accepted) &&
      $stable(out_mode) && $stable(out_estop_latched) &&
      $stable(out_fault_present) && $stable(out_latched_code))
    else $error("stalled result changed");

  // Transient modes are never reported.
  a_no_transient: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mode != MODE_INIT && out_mode != MODE_STOPPING)
    else $error("transient mode reported");

  // Emergency-stop flag only lives in estop mode.
  a_estop_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_estop_latched |-> out_mode == MODE_ESTOP)
    else $error("estop flag outside estop mode");

  // Faulted mode always carries a latched fault.
  a_fault_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode == MODE_FAULTED |-> out_fault_present)
    else $error("faulted mode without fault");

  // Code reads zero when no fault is latched.
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fault_present |-> out_latched_code == '0)
    else $error("fault code without fault");

endmodule

bind machine_mode_interlock_fsm_unit mmi_checker u_mmi_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_accepted      (out_accepted),
  .out_mode          (out_mode),
  .out_estop_latched (out_estop_latched),
  .out_fault_present (out_fault_present),
  .out_latched_code  (out_latched_code)
);

/* bench/machine_mode_interlock_fsm_unit_tb.sv */
// Self-checking testbench for the machine mode interlock controller.
module machine_mode_interlock_fsm_unit_tb
  import mmi_pkg::*;
();

  localparam int FaultCodeBits = 8;
  localparam logic [CodeBits-1:0] CodeMask = CodeBits'((64'd1 << FaultCodeBits) - 1);
  localparam int RandomCommands = 1350;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 10;

  // Status that one request should report.
  typedef struct packed {
    logic                accepted;
    mode_t               mode;
    logic                estop;
    logic                fault;
    logic [CodeBits-1:0] code;
  } status_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ActionBits-1:0] in_action = '0;
  logic [CodeBits-1:0]   in_fault_code = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_accepted;
  logic [ModeBits-1:0]   out_mode;
  logic                  out_estop_latched;
  logic                  out_fault_present;
  logic [CodeBits-1:0]   out_latched_code;

  // Controller state as the testbench sees it, advanced on each accepted request.
  mode_t               ctrl_mode = MODE_OFFLINE;
  bit                  estop_set = 1'b0;
  bit                  fault_set = 1'b0;
  logic [CodeBits-1:0] fault_code_q = '0;

  status_t pending_status[$];
  int      fail_cnt = 0;
  int      cycle_cnt = 0;
  bit      no_idle = 1'b0;  // suppress gaps and stalls on both sides

  machine_mode_interlock_fsm_unit #(
    .FAULT_CODE_BITS(FaultCodeBits)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_fault_code    (in_fault_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_mode         (out_mode),
    .out_estop_latched(out_estop_latched),
    .out_fault_present(out_fault_present),
    .out_latched_code (out_latched_code)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Mode predictor
  // ---------------------------------------------------------------------------

  // Transition table: estop is reachable from every other mode; running and
  // paused share one row.
  function automatic bit edge_allowed(mode_t from, mode_t to);
    if (to == MODE_ESTOP && from != MODE_ESTOP) return 1'b1;
    case (from)
      MODE_OFFLINE:  return to == MODE_INIT;
      MODE_INIT:     return to == MODE_IDLE || to == MODE_FAULTED;
      MODE_IDLE:     return to == MODE_RUNNING || to == MODE_FAULTED;
      MODE_RUNNING,
      MODE_PAUSED:   return to == MODE_PAUSED || to == MODE_RUNNING ||
                            to == MODE_STOPPING || to == MODE_FAULTED;
      MODE_STOPPING: return to == MODE_IDLE || to == MODE_FAULTED;
      MODE_FAULTED:  return to == MODE_IDLE;
      MODE_ESTOP:    return to == MODE_IDLE;
      default:       return 1'b0;
    endcase
  endfunction

  // Move the mode if the table allows it; pause only from running, and never
  // re-enter running.
  function automatic bit take_edge(mode_t to);
    if (to == MODE_PAUSED && ctrl_mode != MODE_RUNNING) return 1'b0;
    if (to == MODE_RUNNING && ctrl_mode == MODE_RUNNING) return 1'b0;
    if (!edge_allowed(ctrl_mode, to)) return 1'b0;
    ctrl_mode = to;
    return 1'b1;
  endfunction

  // Apply one command and return the status the controller must report.
  function automatic status_t apply_command(logic [ActionBits-1:0] act,
                                            logic [CodeBits-1:0] code);
    status_t s;
    bit      ok;
    ok = 1'b0;
    case (act)
      ACT_INIT: begin
        // pass through init within the same request
        if (take_edge(MODE_INIT)) ok = take_edge(MODE_IDLE);
      end
      ACT_START, ACT_RESUME: begin
        if (!estop_set && !fault_set) ok = take_edge(MODE_RUNNING);
      end
      ACT_PAUSE: ok = take_edge(MODE_PAUSED);
      ACT_STOP: begin
        if (take_edge(MODE_STOPPING)) ok = take_edge(MODE_IDLE);
      end
      ACT_RESET: begin
        if (ctrl_mode == MODE_FAULTED) begin
          fault_set = 1'b0;
          fault_code_q = '0;
          ok = take_edge(MODE_IDLE);
        end else if (ctrl_mode == MODE_ESTOP && !estop_set) begin
          // an earlier fault stays latched across this exit
          ok = take_edge(MODE_IDLE);
        end
      end
      ACT_ESTOP: begin
        if (ctrl_mode != MODE_ESTOP) begin
          estop_set = 1'b1;
          ok = take_edge(MODE_ESTOP);
        end
      end
      ACT_CLEAR_ESTOP: begin
        // clear the flag only; the mode stays put
        if (estop_set) begin
          estop_set = 1'b0;
          ok = 1'b1;
        end
      end
      ACT_FAULT: begin
        // refuse in offline, estop and faulted; a held fault keeps its code
        if (ctrl_mode != MODE_OFFLINE && ctrl_mode != MODE_ESTOP &&
            ctrl_mode != MODE_FAULTED) begin
          if (take_edge(MODE_FAULTED)) begin
            fault_set = 1'b1;
            fault_code_q = code & CodeMask;
            ok = 1'b1;
          end
        end
      end
      default: ;  // unknown codes change nothing
    endcase
    s.accepted = ok;
    s.mode     = ctrl_mode;
    s.estop    = estop_set;
    s.fault    = fault_set;
    s.code     = fault_set ? fault_code_q : '0;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Enter and leave at a falling edge. Hold the request until the controller
  // takes it, then record the status it should produce.
  task automatic send_command(logic [ActionBits-1:0] act, logic [CodeBits-1:0] code);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_fault_code <= code;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_status.push_back(apply_command(act, code));
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and receiver stall
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Check each taken result against the oldest pending status, then draw how
  // long to stall before taking the next one.
  always begin : result_check
    status_t want;
    int      stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
        if (pending_status.size() == 0) begin
          $error("result with no request outstanding");
          fail_cnt++;
        end else begin
          want = pending_status.pop_front();
          check_field("accepted", want.accepted, out_accepted);
          check_field("mode", want.mode, out_mode);
          check_field("estop_latched", want.estop, out_estop_latched);
          check_field("fault_present", want.fault, out_fault_present);
          check_field("latched_code", want.code, out_latched_code);
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 3);
      end
      @(negedge clk);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset only init and estop may leave offline; everything else,
  // fault raise and unknown codes included, is refused.
  task automatic test_offline_refusals();
    send_command(ACT_START, '0);
    send_command(ACT_PAUSE, '0);
    send_command(ACT_STOP, '0);
    send_command(ACT_RESET, '0);
    send_command(ACT_CLEAR_ESTOP, '0);
    send_command(ACT_FAULT, 8'hFF);
    send_command(4'd15, 8'hFF);
    send_command(4'd9, '0);
    // leave offline either through init or straight into estop
    if ($urandom_range(0, 1) != 0) begin
      send_command(ACT_INIT, '0);
    end else begin
      send_command(ACT_ESTOP, '0);
      send_command(ACT_CLEAR_ESTOP, '0);
      send_command(ACT_RESET, '0);
    end
  endtask

  // Normal run cycle: repeated commands refused, resume from idle allowed.
  task automatic test_run_cycle();
    send_command(ACT_INIT, '0);
    send_command(ACT_START, '0);
    send_command(ACT_START, '0);
    send_command(ACT_PAUSE, '0);
    send_command(ACT_PAUSE, '0);
    send_command(ACT_RESUME, '0);
    send_command(ACT_STOP, '0);
    send_command(ACT_RESUME, '0);
  endtask

  // Fault and estop latching: held fault keeps its code, start refused while
  // latched, estop exit keeps the fault, a new fault replaces the old code.
  task automatic test_fault_and_estop();
    send_command(ACT_FAULT, 8'hFF);
    send_command(ACT_FAULT, 8'h00);
    send_command(ACT_START, '0);
    send_command(ACT_ESTOP, '0);
    send_command(ACT_ESTOP, '0);
    send_command(ACT_RESET, '0);
    send_command(ACT_CLEAR_ESTOP, '0);
    send_command(ACT_CLEAR_ESTOP, '0);
    send_command(ACT_RESET, '0);
    send_command(ACT_FAULT, 8'h00);
    send_command(ACT_RESET, '0);
  endtask

  // Pick a command that moves the controller on from where it stands.
  function automatic action_t likely_command();
    int r;
    r = $urandom_range(0, 3);
    case (ctrl_mode)
      MODE_OFFLINE: return ACT_INIT;
      MODE_IDLE: begin
        case (r)
          0:       return ACT_START;
          1:       return ACT_RESUME;
          2:       return ACT_FAULT;
          default: return ACT_ESTOP;
        endcase
      end
      MODE_RUNNING: begin
        case (r)
          0:       return ACT_PAUSE;
          1:       return ACT_STOP;
          2:       return ACT_FAULT;
          default: return ACT_ESTOP;
        endcase
      end
      MODE_PAUSED: begin
        case (r)
          0:       return ACT_RESUME;
          1:       return ACT_STOP;
          2:       return ACT_FAULT;
          default: return ACT_ESTOP;
        endcase
      end
      MODE_FAULTED: return (r == 0) ? ACT_ESTOP : ACT_RESET;
      MODE_ESTOP:   return estop_set ? ACT_CLEAR_ESTOP : ACT_RESET;
      default:      return ACT_INIT;
    endcase
  endfunction

  // Mostly commands that advance the controller, the rest any code at all.
  // Switch idling off for whole stretches now and then.
  task automatic test_random_commands(int count);
    logic [ActionBits-1:0] act;
    int                    sent;
    sent = 0;
    while (sent < count) begin
      if (sent % 50 == 0) no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) act = likely_command();
      else act = ActionBits'($urandom_range(0, 15));
      send_command(act, CodeBits'($urandom_range(0, 255)));
      sent++;
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------

  initial begin : main_sequence
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_offline_refusals();
    test_run_cycle();
    test_fault_and_estop();
    test_random_commands(RandomCommands);
    in_valid <= 1'b0;
    // drain, then watch a little longer for stray results
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("status: fail");
    $finish;
  end

endmodule

/* files.f */
hdl/mmi_pkg.sv
hdl/mmi_decide.sv
hdl/machine_mode_interlock_fsm_unit.sv
hdl/mmi_checker.sv
bench/machine_mode_interlock_fsm_unit_tb.sv
